// ===== hdl/fcwpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcwpd_pkg
// Shared constants, types and state codes of the four channel window peak
// detector.
// ----------------------------------------------------------------------------
package fcwpd_pkg;

    // Number of items held in each channel's sliding window.
    localparam int WINDOW_DEPTH = 32;
    localparam int N_CH         = 4;
    localparam int SAMPLE_W     = 8;
    localparam int ENTRY_W      = N_CH * SAMPLE_W;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int CH_IDX_W     = 2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd100;

    typedef logic [N_CH-1:0][SAMPLE_W-1:0] t_lane_arr;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    // Control of the shared min/max unit.
    typedef struct packed {
        logic clear;
        logic update;
    } t_mm_ctrl;

endpackage

// ===== hdl/fcwpd_in_if.sv =====
// ----------------------------------------------------------------------------
// fcwpd_in_if
// Request channel carrying one sample of each of the four channels.
// ----------------------------------------------------------------------------
interface fcwpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch1_sample;
    logic [7:0] ch2_sample;
    logic [7:0] ch3_sample;
    logic [7:0] ch4_sample;

    modport source (
        output valid, ch1_sample, ch2_sample, ch3_sample, ch4_sample,
        input  ready
    );
    modport sink (
        input  valid, ch1_sample, ch2_sample, ch3_sample, ch4_sample,
        output ready
    );
endinterface

// ===== hdl/fcwpd_out_if.sv =====
// ----------------------------------------------------------------------------
// fcwpd_out_if
// Result channel carrying the four swings and the strongest channel report.
// ----------------------------------------------------------------------------
interface fcwpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch1_swing;
    logic [7:0] ch2_swing;
    logic [7:0] ch3_swing;
    logic [7:0] ch4_swing;
    logic [1:0] strongest_channel;
    logic [7:0] strongest_swing;
    logic       detected;

    modport source (
        output valid, ch1_swing, ch2_swing, ch3_swing, ch4_swing,
               strongest_channel, strongest_swing, detected,
        input  ready
    );
    modport sink (
        input  valid, ch1_swing, ch2_swing, ch3_swing, ch4_swing,
               strongest_channel, strongest_swing, detected,
        output ready
    );
endinterface

// ===== hdl/fcwpd_minmax.sv =====
// ----------------------------------------------------------------------------
// fcwpd_minmax
// Shared compare unit: keeps a running minimum and maximum per channel lane
// and presents the swing of each lane.
// ----------------------------------------------------------------------------
module fcwpd_minmax (
    input  logic                               i_clk,
    input  fcwpd_pkg::t_mm_ctrl                i_ctrl,
    input  logic [fcwpd_pkg::ENTRY_W-1:0]      i_entry,
    output fcwpd_pkg::t_lane_arr               o_swing
);
    import fcwpd_pkg::*;

    t_lane_arr r_min;
    t_lane_arr r_max;
    t_lane_arr lane_val;

    assign lane_val = i_entry;

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < N_CH; ch++) begin
            if (i_ctrl.clear) begin
                r_min[ch] <= '1;
                r_max[ch] <= '0;
            end else if (i_ctrl.update) begin
                if (lane_val[ch] < r_min[ch]) begin
                    r_min[ch] <= lane_val[ch];
                end
                if (lane_val[ch] > r_max[ch]) begin
                    r_max[ch] <= lane_val[ch];
                end
            end
        end
    end

    // At least one entry is folded in before the swing is used, so the
    // maximum never lies below the minimum.
    always_comb begin
        for (int ch = 0; ch < N_CH; ch++) begin
            o_swing[ch] = r_max[ch] - r_min[ch];
        end
    end

endmodule

// ===== hdl/four_channel_window_peak_detector.sv =====
// ----------------------------------------------------------------------------
// four_channel_window_peak_detector
// Each accepted request is written to the window, then the stored items (1 up
// to WINDOW_DEPTH) are scanned through the single read port of the window
// memory, one entry per cycle; the drain and result states then load the result
// register, and only then is a new request taken.
// Reset: synchronous active low; clears the sequencer, write slot, fill count
// and result valid, and loads the threshold with 100. The window needs no clear.
// ----------------------------------------------------------------------------
module four_channel_window_peak_detector (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcwpd_in_if.sink          i_in_if,
    fcwpd_out_if.source       o_out_if,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);
    import fcwpd_pkg::*;

    // Window memory: one 32-bit entry per item, channel one in the low byte.
    // Entries are written in order 0, 1, 2 ... and wrap, so the stored items
    // are always entries 0 up to fill count minus one.
    logic [ENTRY_W-1:0] r_window [WINDOW_DEPTH];

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_wr_slot, n_wr_slot;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [SLOT_W-1:0]  r_rd_addr, n_rd_addr;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic [SAMPLE_W-1:0] r_threshold;

    logic               r_out_valid, n_out_valid;
    t_lane_arr          r_out_swing;
    logic [CH_IDX_W-1:0] r_out_ch;
    logic [SAMPLE_W-1:0] r_out_best;
    logic               r_out_det;

    logic               in_fire;
    logic               rd_en;
    logic               load_out;
    logic               last_addr;
    logic [ENTRY_W-1:0] in_entry;
    t_mm_ctrl           mm_ctrl;
    t_lane_arr          swing;
    logic [CH_IDX_W-1:0] best_ch;
    logic [SAMPLE_W-1:0] best_sw;

    // The block takes a new request only between items; the result register
    // lets a finished result wait while the next request is accepted.
    assign i_in_if.ready = (r_state == ST_IDLE);
    assign in_fire       = i_in_if.valid && i_in_if.ready;
    assign in_entry      = {i_in_if.ch4_sample, i_in_if.ch3_sample,
                            i_in_if.ch2_sample, i_in_if.ch1_sample};

    // The scan ends at the entry just below the fill count.
    assign last_addr = (FILL_W'({1'b0, r_rd_addr}) + FILL_W'(1)) == r_fill;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Window memory: written on an accepted request, read during the scan.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_window[r_wr_slot] <= in_entry;
        end
        if (rd_en) begin
            r_rd_data <= r_window[r_rd_addr];
        end
    end

    // Sequencer and output register control.
    always_comb begin
        n_state     = r_state;
        n_wr_slot   = r_wr_slot;
        n_fill      = r_fill;
        n_rd_addr   = r_rd_addr;
        n_out_valid = r_out_valid;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        mm_ctrl     = '{clear: 1'b0, update: r_rd_vld};

        if (r_out_valid && o_out_if.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_wr_slot = (r_wr_slot == SLOT_W'(WINDOW_DEPTH - 1)) ?
                                '0 : r_wr_slot + SLOT_W'(1);
                    if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    n_rd_addr     = '0;
                    mm_ctrl.clear = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (last_addr) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_rd_addr = r_rd_addr + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                // The last read entry is folded into the min/max this cycle.
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || o_out_if.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_slot   <= '0;
            r_fill      <= '0;
            r_rd_addr   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_slot   <= n_wr_slot;
            r_fill      <= n_fill;
            r_rd_addr   <= n_rd_addr;
            r_rd_vld    <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Shared min/max unit fed one window entry per cycle.
    fcwpd_minmax u_minmax (
        .i_clk   (i_clk),
        .i_ctrl  (mm_ctrl),
        .i_entry (r_rd_data),
        .o_swing (swing)
    );

    // Strongest channel: a later channel wins only with a strictly larger
    // swing, so ties go to the lowest channel.
    always_comb begin
        best_ch = '0;
        best_sw = swing[0];
        for (int ch = 1; ch < N_CH; ch++) begin
            if (swing[ch] > best_sw) begin
                best_ch = CH_IDX_W'(ch);
                best_sw = swing[ch];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_swing <= swing;
            r_out_ch    <= best_ch;
            r_out_best  <= best_sw;
            r_out_det   <= (best_sw > r_threshold);
        end
    end

    assign o_out_if.valid             = r_out_valid;
    assign o_out_if.ch1_swing         = r_out_swing[0];
    assign o_out_if.ch2_swing         = r_out_swing[1];
    assign o_out_if.ch3_swing         = r_out_swing[2];
    assign o_out_if.ch4_swing         = r_out_swing[3];
    assign o_out_if.strongest_channel = r_out_ch;
    assign o_out_if.strongest_swing   = r_out_best;
    assign o_out_if.detected          = r_out_det;

endmodule

// ===== bench/four_channel_window_peak_detector_tb.sv =====
// ----------------------------------------------------------------------------
// four_channel_window_peak_detector_tb
// Drives four-channel sample requests into the window peak detector and tracks
// a private copy of every channel's sliding window. Each returned report is
// checked field by field against the swings computed from that copy. The run
// starts with a short hand-picked sequence, then sweeps the detection
// threshold through its extremes and several mid values. Between threshold
// changes it sends long random sample streams. The sender pauses in bursts
// and the receiver stalls on a rotating pattern of its own.
// ----------------------------------------------------------------------------
module four_channel_window_peak_detector_tb;

    import fcwpd_pkg::*;

    // Generous ceiling on the run; the slowest legal run is well below it.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Cycles allowed to pass after the last report before the verdict.
    localparam int SETTLE_CYCLES = 40;
    // Random requests sent under each threshold setting.
    localparam int PHASE_ITEMS   = 235;
    localparam int N_PHASES      = 7;

    // One report of the block: the four swings, the winning channel, its
    // swing and the detection flag.
    typedef struct packed {
        t_lane_arr    swing;
        logic [1:0]   strongest;
        logic [7:0]   peak;
        logic         detected;
    } swing_report_t;

    // Shapes of the random sample streams.
    typedef enum int {
        STREAM_UNIFORM,
        STREAM_QUIET,
        STREAM_FLAT,
        STREAM_PULSE,
        STREAM_RAILS
    } stream_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    fcwpd_in_if  in_req ();
    fcwpd_out_if out_res ();

    four_channel_window_peak_detector uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_if     (in_req),
        .o_out_if    (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Private copy of the block's state. The window itself is never cleared;
    // only entries below stored_count take part in a report.
    t_lane_arr   window_store [WINDOW_DEPTH];
    int unsigned store_slot     = 0;
    int unsigned stored_count   = 0;
    logic [7:0]  threshold_copy = THRESHOLD_RESET;

    // Requests waiting to be sent and reports waiting to come back.
    t_lane_arr     sample_backlog [$];
    swing_report_t swing_reports_due [$];

    int unsigned mismatch_count = 0;
    int unsigned reports_seen   = 0;
    int unsigned cycle_count    = 0;

    // Sender pacing: requests go out in bursts with pauses between them.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // Receiver pacing: ready follows a 16-bit pattern that rotates every
    // cycle and is reloaded each time the 6-bit pattern age wraps.
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [5:0]  pattern_age   = '0;

    int unsigned threshold_plan [N_PHASES];

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Window tracker. Stores the sample at the write slot, advances the slot
    // and fill count, then scans the filled part of the window per channel.
    // A later channel wins only with a strictly larger swing, so ties stay
    // with the lowest channel, and the flag needs a swing strictly above the
    // threshold.
    // ------------------------------------------------------------------------
    function automatic swing_report_t track_window_swings(t_lane_arr sample);
        swing_report_t rpt;
        logic [7:0] lo;
        logic [7:0] hi;
        window_store[store_slot] = sample;
        store_slot = (store_slot == WINDOW_DEPTH - 1) ? 0 : store_slot + 1;
        if (stored_count < WINDOW_DEPTH) begin
            stored_count++;
        end
        for (int ch = 0; ch < N_CH; ch++) begin
            lo = 8'hFF;
            hi = 8'h00;
            for (int i = 0; i < stored_count; i++) begin
                if (window_store[i][ch] < lo) lo = window_store[i][ch];
                if (window_store[i][ch] > hi) hi = window_store[i][ch];
            end
            rpt.swing[ch] = hi - lo;
        end
        rpt.strongest = 2'd0;
        rpt.peak      = rpt.swing[0];
        for (int ch = 1; ch < N_CH; ch++) begin
            if (rpt.swing[ch] > rpt.peak) begin
                rpt.strongest = ch[1:0];
                rpt.peak      = rpt.swing[ch];
            end
        end
        rpt.detected = (rpt.peak > threshold_copy);
        return rpt;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        $display("MISMATCH report %0d %s: got %0d, want %0d",
                 reports_seen, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A request that is not yet taken is held unchanged. When
    // a request is taken, its report is worked out from the samples on the
    // bus at that edge, and the next request or a pause follows.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_req.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (!in_req.valid || in_req.ready) begin
            if (in_req.valid) begin
                swing_reports_due.push_back(track_window_swings(
                    {in_req.ch4_sample, in_req.ch3_sample,
                     in_req.ch2_sample, in_req.ch1_sample}));
            end
            if (gap_left > 0 || sample_backlog.size() == 0) begin
                in_req.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                in_req.valid      <= 1'b1;
                in_req.ch1_sample <= sample_backlog[0][0];
                in_req.ch2_sample <= sample_backlog[0][1];
                in_req.ch3_sample <= sample_backlog[0][2];
                in_req.ch4_sample <= sample_backlog[0][3];
                void'(sample_backlog.pop_front());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    // Half the pauses are empty so that back-to-back
                    // stretches occur; the long ones reach every phase
                    // of the block's window scan.
                    case ($urandom_range(0, 7))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5:       gap_left = $urandom_range(1, 4);
                        6:          gap_left = $urandom_range(5, 20);
                        default:    gap_left = $urandom_range(21, 45);
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_res.ready <= 1'b0;
        end else begin
            out_res.ready <= stall_pattern[0];
            pattern_age   <= pattern_age + 1'b1;
            if (pattern_age == '0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= 16'hFFFF;
                    1:       stall_pattern <= 16'($urandom);
                    2:       stall_pattern <= 16'($urandom | $urandom);
                    default: stall_pattern <= 16'($urandom & $urandom);
                endcase
            end else begin
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report checker. Every report taken is compared with the oldest one
    // still due; a report with nothing due is a failure of its own.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_res.valid && out_res.ready) begin
            if (swing_reports_due.size() == 0) begin
                flag_mismatch("report with no request outstanding", 1, 0);
            end else begin : check_report
                swing_report_t due;
                due = swing_reports_due.pop_front();
                if (out_res.ch1_swing !== due.swing[0])
                    flag_mismatch("ch1_swing", out_res.ch1_swing, due.swing[0]);
                if (out_res.ch2_swing !== due.swing[1])
                    flag_mismatch("ch2_swing", out_res.ch2_swing, due.swing[1]);
                if (out_res.ch3_swing !== due.swing[2])
                    flag_mismatch("ch3_swing", out_res.ch3_swing, due.swing[2]);
                if (out_res.ch4_swing !== due.swing[3])
                    flag_mismatch("ch4_swing", out_res.ch4_swing, due.swing[3]);
                if (out_res.strongest_channel !== due.strongest)
                    flag_mismatch("strongest_channel", out_res.strongest_channel,
                                  due.strongest);
                if (out_res.strongest_swing !== due.peak)
                    flag_mismatch("strongest_swing", out_res.strongest_swing, due.peak);
                if (out_res.detected !== due.detected)
                    flag_mismatch("detected", out_res.detected, due.detected);
            end
            reports_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Waits until every queued request has been taken and every report has
    // come back. Each request gives exactly one report, so the block is idle
    // then.
    task automatic drain_requests();
        do begin
            @(posedge clk);
        end while (sample_backlog.size() != 0 || in_req.valid
                   || swing_reports_due.size() != 0);
    endtask

    // Threshold write; only called while the block is idle.
    task automatic load_threshold(input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        threshold_copy = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Queues random samples in segments of one shape each. Quiet segments keep
    // swings small, so mid-range thresholds are hit exactly at times; pulse
    // segments add occasional full-range spikes; flat segments run longer than
    // the window so that old extremes age out and swings fall back to zero.
    task automatic queue_sample_streams(input int unsigned count);
        stream_mode_t mode;
        int unsigned  seg_len;
        int           level [N_CH];
        int           amp;
        int           val;
        t_lane_arr    sample;
        t_lane_arr    flat_value;
        while (count > 0) begin
            mode = stream_mode_t'($urandom_range(0, 4));
            seg_len = (mode == STREAM_FLAT) ? $urandom_range(33, 48)
                                            : $urandom_range(1, 48);
            if (seg_len > count) seg_len = count;
            amp = $urandom_range(0, 31);
            flat_value = $urandom;
            foreach (level[ch]) level[ch] = $urandom_range(0, 255);
            repeat (seg_len) begin
                for (int ch = 0; ch < N_CH; ch++) begin
                    val = level[ch] + $urandom_range(0, 2 * amp) - amp;
                    if (val < 0) val = 0;
                    if (val > 255) val = 255;
                    case (mode)
                        STREAM_UNIFORM: sample[ch] = 8'($urandom_range(0, 255));
                        STREAM_FLAT:    sample[ch] = flat_value[ch];
                        STREAM_RAILS:   sample[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        STREAM_PULSE:   sample[ch] = ($urandom_range(0, 3) == 0)
                                                     ? 8'($urandom_range(0, 255))
                                                     : 8'(val);
                        default:        sample[ch] = 8'(val);
                    endcase
                end
                sample_backlog.push_back(sample);
            end
            count -= seg_len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 8'h00;
        in_req.valid      = 1'b0;
        in_req.ch1_sample = 8'h00;
        in_req.ch2_sample = 8'h00;
        in_req.ch3_sample = 8'h00;
        in_req.ch4_sample = 8'h00;
        out_res.ready     = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Hand-picked requests under the reset threshold of 100. Samples are
        // listed channel four first. The first request alone in the window
        // gives zero swing everywhere and channel one by the tie rule. Next,
        // a swing equal to the threshold must not detect. A two-way tie at
        // 101 goes to channel one. Channels three and four then take the lead
        // in turn. Full-scale samples tie all four channels at 255. Two
        // alternating bit patterns finish the set.
        sample_backlog.push_back({8'd0,   8'd0,   8'd0,   8'd0});
        sample_backlog.push_back({8'd0,   8'd0,   8'd0,   8'd100});
        sample_backlog.push_back({8'd0,   8'd0,   8'd101, 8'd101});
        sample_backlog.push_back({8'd0,   8'd150, 8'd0,   8'd0});
        sample_backlog.push_back({8'd255, 8'd0,   8'd0,   8'd0});
        sample_backlog.push_back({8'd255, 8'd255, 8'd255, 8'd255});
        sample_backlog.push_back({8'hF0,  8'h0F,  8'hAA,  8'h55});
        sample_backlog.push_back({8'h0F,  8'hF0,  8'h55,  8'hAA});
        drain_requests();

        // Threshold sweep: both extremes, values next to them, a small value
        // that quiet streams straddle, and two random settings.
        threshold_plan = '{0, 255, 12, 1, 254, 0, 0};
        threshold_plan[5] = $urandom_range(2, 253);
        threshold_plan[6] = $urandom_range(2, 253);
        for (int p = 0; p < N_PHASES; p++) begin
            load_threshold(8'(threshold_plan[p]));
            queue_sample_streams(PHASE_ITEMS);
            drain_requests();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
